### sv/four_channel_pwm_with_byte_commands_macros.svh
// assertion helpers used by the checker file
`ifndef FOUR_CHANNEL_PWM_WITH_BYTE_COMMANDS_MACROS_SVH
`define FOUR_CHANNEL_PWM_WITH_BYTE_COMMANDS_MACROS_SVH

// clocked check, muted while reset is asserted
`define FCPWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define FCPWM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/fcpwm_pkg.sv
package fcpwm_pkg;

    localparam int PERIOD_TICKS = 1025;
    localparam int CHANNELS     = 4;
    localparam int NUM_SLOTS    = 4;
    localparam int PHASE_W      = 11;
    localparam int DUTY_W       = 10;
    localparam int BYTE_W       = 8;
    localparam int HIGH_BIT     = 7;
    localparam int ID_LSB       = 5;
    localparam int ID_W         = 2;
    localparam int VALUE_W      = 5;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [ID_W-1:0]    chan_id_t;

    localparam duty_t DUTY_RESET = duty_t'(800);
    localparam logic [PHASE_W:0] PERIOD_END = (PHASE_W + 1)'(PERIOD_TICKS);
    localparam logic [ID_W:0] CHANNEL_COUNT = (ID_W + 1)'(CHANNELS);

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_NONE     = 2'd0,
        STATUS_UPDATED  = 2'd1,
        STATUS_REJECTED = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t   op;
        byte_t data;
    } item_t;

    typedef duty_t [NUM_SLOTS-1:0] duty_arr_t;

    typedef struct packed
    {
        duty_arr_t duty;
        status_t   status;
    } cmd_result_t;

endpackage

### sv/four_channel_pwm_with_byte_commands.sv
// Four-channel PWM from one shared phase counter, one result beat per input beat. An input
// beat with s_tuser[0] low is a timer tick that advances the phase (wrapping at the period end);
// with s_tuser[0] high, s_tdata is a serial byte: a low byte (bit 7 clear) and a following
// high byte (bit 7 set) with equal channel ids in bits 6:5 load a 10-bit duty. Each result
// carries the four output levels after the beat and whether a command completed. The block
// takes one beat per clock cycle while m_tready keeps the results flowing; a beat passes through
// an input register and then a result register on its way to m_tdata, and the result register
// lets the next beat enter while a result is still waiting on m_tready.
module four_channel_pwm_with_byte_commands
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic [0:0] s_tuser,   // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] drive, [5:4] command_status, [7:6] zero
);

    logic                            in_valid_reg;
    logic                            in_valid_next;
    fcpwm_pkg::item_t                in_item_reg;
    fcpwm_pkg::item_t                in_item_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [fcpwm_pkg::NUM_SLOTS-1:0] out_drive_reg;
    logic [fcpwm_pkg::NUM_SLOTS-1:0] out_drive_next;
    fcpwm_pkg::status_t              out_status_reg;
    fcpwm_pkg::status_t              out_status_next;
    logic                            out_free;
    logic                            step;
    fcpwm_pkg::cmd_result_t          cmd_result;
    logic [fcpwm_pkg::NUM_SLOTS-1:0] drive_next;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    fcpwm_cmd u_cmd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (cmd_result)
    );

    fcpwm_drive u_drive
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .op         (in_item_reg.op),
        .duty       (cmd_result.duty),
        .drive_next (drive_next)
    );

    always_comb
    begin
        in_valid_next      = s_tready ? s_tvalid : in_valid_reg;
        in_item_next.op    = fcpwm_pkg::op_t'(s_tuser[0]);
        in_item_next.data  = s_tdata;
        out_valid_next     = out_free ? step : out_valid_reg;
        out_drive_next     = drive_next;
        out_status_next    = cmd_result.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_next;
        end
        if (step)
        begin
            out_drive_reg  <= out_drive_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_drive_reg};

endmodule

### sv/fcpwm_cmd.sv
module fcpwm_cmd
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  fcpwm_pkg::item_t      item,
    output fcpwm_pkg::cmd_result_t result
);

    fcpwm_pkg::byte_t     staged_low_reg;
    fcpwm_pkg::byte_t     staged_low_next;
    fcpwm_pkg::byte_t     staged_high_reg;
    fcpwm_pkg::byte_t     staged_high_next;
    fcpwm_pkg::duty_arr_t duty_reg;
    fcpwm_pkg::duty_arr_t duty_next;
    fcpwm_pkg::status_t   status;
    fcpwm_pkg::chan_id_t  id_lo;
    fcpwm_pkg::chan_id_t  id_hi;

    always_comb
    begin
        staged_low_next  = staged_low_reg;
        staged_high_next = staged_high_reg;
        duty_next        = duty_reg;
        status           = fcpwm_pkg::STATUS_NONE;
        if (item.op == fcpwm_pkg::OP_BYTE)
        begin
            if (item.data[fcpwm_pkg::HIGH_BIT])
            begin
                // a high byte only counts once a low byte is waiting
                if (staged_low_reg != '0)
                begin
                    staged_high_next = item.data;
                end
            end
            else
            begin
                staged_low_next = item.data;
            end
        end
        id_lo = staged_low_next[fcpwm_pkg::ID_LSB +: fcpwm_pkg::ID_W];
        id_hi = staged_high_next[fcpwm_pkg::ID_LSB +: fcpwm_pkg::ID_W];
        if (item.op == fcpwm_pkg::OP_BYTE && staged_low_next != '0 && staged_high_next != '0)
        begin
            if (id_lo == id_hi && {1'b0, id_lo} < fcpwm_pkg::CHANNEL_COUNT)
            begin
                duty_next[id_lo] = {staged_high_next[fcpwm_pkg::VALUE_W-1:0],
                                    staged_low_next[fcpwm_pkg::VALUE_W-1:0]};
                status = fcpwm_pkg::STATUS_UPDATED;
            end
            else
            begin
                status = fcpwm_pkg::STATUS_REJECTED;
            end
            staged_low_next  = '0;
            staged_high_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_low_reg  <= '0;
            staged_high_reg <= '0;
            duty_reg        <= {fcpwm_pkg::NUM_SLOTS{fcpwm_pkg::DUTY_RESET}};
        end
        else if (step)
        begin
            staged_low_reg  <= staged_low_next;
            staged_high_reg <= staged_high_next;
            duty_reg        <= duty_next;
        end
    end

    assign result.duty   = duty_next;
    assign result.status = status;

endmodule

### sv/fcpwm_drive.sv
module fcpwm_drive
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  fcpwm_pkg::op_t              op,
    input  fcpwm_pkg::duty_arr_t        duty,
    output logic [fcpwm_pkg::NUM_SLOTS-1:0] drive_next
);

    fcpwm_pkg::phase_t                phase_reg;
    fcpwm_pkg::phase_t                phase_next;
    logic [fcpwm_pkg::PHASE_W:0]      phase_sum;
    logic [fcpwm_pkg::NUM_SLOTS-1:0]  drive_level_reg;

    assign phase_sum = {1'b0, phase_reg} + (fcpwm_pkg::PHASE_W + 1)'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (op == fcpwm_pkg::OP_TICK)
        begin
            if (phase_sum >= fcpwm_pkg::PERIOD_END)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_sum[fcpwm_pkg::PHASE_W-1:0];
            end
        end
    end

    // equal phase and duty keeps the previous level
    always_comb
    begin
        drive_next = drive_level_reg;
        for (int ch = 0; ch < fcpwm_pkg::NUM_SLOTS; ch++)
        begin
            if (ch >= fcpwm_pkg::CHANNELS)
            begin
                drive_next[ch] = 1'b0;
            end
            else if (phase_next > {1'b0, duty[ch]})
            begin
                drive_next[ch] = 1'b0;
            end
            else if (phase_next < {1'b0, duty[ch]})
            begin
                drive_next[ch] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            drive_level_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            drive_level_reg <= drive_next;
        end
    end

endmodule

### sv/fcpwm_checker.sv
`include "four_channel_pwm_with_byte_commands_macros.svh"

module fcpwm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic [1:0] status_seen;

    assign status_seen = m_tdata[5:4];

    // no result beat can come out of a reset
    `FCPWM_ASSERT_RST(a_no_beat_after_reset, !rst_n |=> !m_tvalid, "result beat right after reset")

    // an emptied pipe is open for input
    `FCPWM_ASSERT_RST(a_ready_in_reset, !rst_n |=> s_tready, "input not ready after reset")

    `FCPWM_ASSERT(a_status_code, m_tvalid |-> status_seen <= fcpwm_pkg::STATUS_REJECTED, "bad status")

    `FCPWM_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[7:6] == 2'b00, "pad bits set")

    `FCPWM_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall lost")

endmodule

bind four_channel_pwm_with_byte_commands fcpwm_checker u_fcpwm_checker (.*);
